// ----- rtl/qsvg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the qubit state-vector gate engine.
package qsvg_pkg;

    // Field widths fixed by the item format
    localparam int OPC_W   = 3;
    localparam int QUBIT_W = 3;
    localparam int IDX_W   = 8;
    localparam int DATA_W  = 16;
    localparam int STAT_W  = 2;
    localparam int QCNT_W  = 4;
    localparam int WORD_W  = 2 * DATA_W;

    // Default store size and qubit count after reset
    localparam int               MAX_QUBITS_DEF = 8;
    localparam logic [QCNT_W-1:0] QCOUNT_RESET  = 4'd8;

    // Hadamard scaling: 1/sqrt(2) in Q14, round half up, drop 14 fraction bits
    localparam int                 FRAC_BITS = 14;
    localparam logic signed [15:0] HAD_SCALE = 16'sd11585;
    localparam logic signed [31:0] HAD_ROUND = 32'sd8192;

    typedef enum logic [OPC_W-1:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_X     = 3'd2,
        OP_HAD   = 3'd3,
        OP_CNOT  = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_QUBIT = 2'd1,
        ST_INDEX = 2'd2
    } t_status;

    // What the controller has to do with an item
    typedef enum logic [2:0] {
        K_NONE,
        K_WRITE,
        K_READ,
        K_SWAP,
        K_HAD
    } t_op_kind;

    // Read address select
    typedef enum logic [1:0] {
        RD_IDX,
        RD_A,
        RD_B
    } t_rd_sel;

    // Write address and data select
    typedef enum logic [2:0] {
        WR_INPUT,
        WR_A_RDATA,
        WR_B_RA,
        WR_A_HAD,
        WR_B_HAD
    } t_wr_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_X_RA,
        S_X_RB,
        S_X_WA,
        S_X_WB,
        S_H_RA,
        S_H_RB,
        S_H_CB,
        S_H_MS,
        S_H_WA,
        S_H_WB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     issue_a;
        logic     cap_a;
        logic     cap_b;
        logic     cap_read;
        logic     mul_en;
        logic     mul_diff;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_rd_sel  rd_sel;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op_kind kind;
        logic     last;
    } t_dp_status;

endpackage

// ----- rtl/qsvg_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module qsvg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/qsvg_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: qubit count register, item decode, pair walker, Hadamard unit, store, result.
module qsvg_datapath #(
    parameter int MAX_QUBITS = qsvg_pkg::MAX_QUBITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic        [qsvg_pkg::QCNT_W-1:0]  i_cfg_data,
    input  logic        [qsvg_pkg::OPC_W-1:0]   i_opcode,
    input  logic        [qsvg_pkg::QUBIT_W-1:0] i_target_qubit,
    input  logic        [qsvg_pkg::QUBIT_W-1:0] i_control_qubit,
    input  logic        [qsvg_pkg::IDX_W-1:0]   i_amp_index,
    input  logic signed [qsvg_pkg::DATA_W-1:0]  i_write_real,
    input  logic signed [qsvg_pkg::DATA_W-1:0]  i_write_imag,
    input  qsvg_pkg::t_dp_cmd                   i_cmd,
    output qsvg_pkg::t_dp_status                o_status,
    output logic signed [qsvg_pkg::DATA_W-1:0]  o_read_real,
    output logic signed [qsvg_pkg::DATA_W-1:0]  o_read_imag,
    output logic        [qsvg_pkg::STAT_W-1:0]  o_status_code
);

    import qsvg_pkg::*;

    localparam int AddrW = MAX_QUBITS;
    localparam int Depth = 1 << MAX_QUBITS;
    localparam int CmpW  = ((MAX_QUBITS > IDX_W) ? MAX_QUBITS : IDX_W) + 1;

    // Qubit count register and its clamped value
    logic [QCNT_W-1:0] r_qcount;
    logic [QCNT_W-1:0] w_eff_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcount <= QCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_qcount <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_qcount == '0) begin
            w_eff_n = QCNT_W'(1);
        end else if (r_qcount > QCNT_W'(MAX_QUBITS)) begin
            w_eff_n = QCNT_W'(MAX_QUBITS);
        end else begin
            w_eff_n = r_qcount;
        end
    end

    // Range checks on the incoming item
    logic [CmpW-1:0] w_dim;
    logic [CmpW-1:0] w_idx_ext;
    logic            w_idx_ok;
    logic            w_tq_ok;
    logic            w_cq_ok;
    t_op_kind        w_kind;
    t_status         w_stat;

    assign w_dim     = CmpW'(1) << w_eff_n;
    assign w_idx_ext = CmpW'(i_amp_index);
    assign w_idx_ok  = w_idx_ext < w_dim;
    assign w_tq_ok   = QCNT_W'(i_target_qubit) < w_eff_n;
    assign w_cq_ok   = QCNT_W'(i_control_qubit) < w_eff_n;

    // Item decode
    always_comb begin
        w_kind = K_NONE;
        w_stat = ST_OK;
        unique case (i_opcode)
            OP_WRITE, OP_READ: begin
                if (!w_idx_ok) begin
                    w_stat = ST_INDEX;
                end else begin
                    w_kind = (i_opcode == OP_WRITE) ? K_WRITE : K_READ;
                end
            end
            OP_X: begin
                if (!w_tq_ok) begin
                    w_stat = ST_QUBIT;
                end else begin
                    w_kind = K_SWAP;
                end
            end
            OP_HAD: begin
                if (!w_tq_ok) begin
                    w_stat = ST_QUBIT;
                end else begin
                    w_kind = K_HAD;
                end
            end
            OP_CNOT: begin
                if (!w_tq_ok || !w_cq_ok) begin
                    w_stat = ST_QUBIT;
                end else begin
                    w_kind = K_SWAP;
                end
            end
            default: begin
                w_kind = K_NONE;
                w_stat = ST_OK;
            end
        endcase
    end

    // Gate masks, latched when the item is taken
    logic [AddrW-1:0] r_tmask;
    logic [AddrW-1:0] r_cmask;
    logic             r_is_cnot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tmask   <= AddrW'(1) << i_target_qubit;
            r_cmask   <= AddrW'(1) << i_control_qubit;
            r_is_cnot <= (i_opcode == OP_CNOT);
        end
    end

    // Pair walker: insert a zero at the target bit of the pair number
    logic [AddrW-1:0] r_pair;
    logic [AddrW-1:0] r_addr_a;
    logic [AddrW-1:0] r_addr_b;
    logic             r_sel;
    logic             r_last;
    logic [AddrW-1:0] w_low;
    logic [AddrW-1:0] w_a_cur;
    logic [AddrW-1:0] w_last_pair;
    logic             w_sel;

    assign w_low       = r_tmask - AddrW'(1);
    assign w_a_cur     = ((r_pair & ~w_low) << 1) | (r_pair & w_low);
    assign w_last_pair = (AddrW'(1) << (w_eff_n - QCNT_W'(1))) - AddrW'(1);
    assign w_sel       = r_is_cnot ? |(w_a_cur & r_cmask) : 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pair <= '0;
        end else if (i_cmd.issue_a) begin
            r_pair   <= r_pair + AddrW'(1);
            r_addr_a <= w_a_cur;
            r_addr_b <= w_a_cur | r_tmask;
            r_sel    <= w_sel;
            r_last   <= (r_pair == w_last_pair);
        end
    end

    // Amplitude store
    logic              w_we;
    logic [AddrW-1:0]  w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic [AddrW-1:0]  w_raddr;
    logic [WORD_W-1:0] w_rdata;

    qsvg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (Depth)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Captured pair operands
    logic signed [DATA_W-1:0] r_a_re;
    logic signed [DATA_W-1:0] r_a_im;
    logic signed [DATA_W-1:0] r_b_re;
    logic signed [DATA_W-1:0] r_b_im;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_a_re <= w_rdata[WORD_W-1:DATA_W];
            r_a_im <= w_rdata[DATA_W-1:0];
        end
        if (i_cmd.cap_b) begin
            r_b_re <= w_rdata[WORD_W-1:DATA_W];
            r_b_im <= w_rdata[DATA_W-1:0];
        end
    end

    // Hadamard: sum or difference, times the scale, product registered
    logic signed [DATA_W:0] w_s_re;
    logic signed [DATA_W:0] w_s_im;
    logic signed [31:0]     r_p_re;
    logic signed [31:0]     r_p_im;
    logic signed [31:0]     w_rnd_re;
    logic signed [31:0]     w_rnd_im;

    always_comb begin
        if (i_cmd.mul_diff) begin
            w_s_re = (DATA_W+1)'(r_a_re) - (DATA_W+1)'(r_b_re);
            w_s_im = (DATA_W+1)'(r_a_im) - (DATA_W+1)'(r_b_im);
        end else begin
            w_s_re = (DATA_W+1)'(r_a_re) + (DATA_W+1)'(r_b_re);
            w_s_im = (DATA_W+1)'(r_a_im) + (DATA_W+1)'(r_b_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_p_re <= 32'(w_s_re) * 32'(HAD_SCALE);
            r_p_im <= 32'(w_s_im) * 32'(HAD_SCALE);
        end
    end

    assign w_rnd_re = r_p_re + HAD_ROUND;
    assign w_rnd_im = r_p_im + HAD_ROUND;

    // Store address and data selection
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_IDX:  w_raddr = w_idx_ext[AddrW-1:0];
            RD_A:    w_raddr = w_a_cur;
            RD_B:    w_raddr = r_addr_b;
            default: w_raddr = w_idx_ext[AddrW-1:0];
        endcase
    end

    always_comb begin
        w_we = i_cmd.wr_en & r_sel;
        unique case (i_cmd.wr_sel)
            WR_INPUT: begin
                w_we    = i_cmd.wr_en;
                w_waddr = w_idx_ext[AddrW-1:0];
                w_wdata = {i_write_real, i_write_imag};
            end
            WR_A_RDATA: begin
                w_waddr = r_addr_a;
                w_wdata = w_rdata;
            end
            WR_B_RA: begin
                w_waddr = r_addr_b;
                w_wdata = {r_a_re, r_a_im};
            end
            WR_A_HAD: begin
                w_waddr = r_addr_a;
                w_wdata = {w_rnd_re[FRAC_BITS+DATA_W-1:FRAC_BITS],
                           w_rnd_im[FRAC_BITS+DATA_W-1:FRAC_BITS]};
            end
            WR_B_HAD: begin
                w_waddr = r_addr_b;
                w_wdata = {w_rnd_re[FRAC_BITS+DATA_W-1:FRAC_BITS],
                           w_rnd_im[FRAC_BITS+DATA_W-1:FRAC_BITS]};
            end
            default: begin
                w_we    = 1'b0;
                w_waddr = r_addr_a;
                w_wdata = w_rdata;
            end
        endcase
    end

    // Result staging and output register
    logic signed [DATA_W-1:0] r_res_re;
    logic signed [DATA_W-1:0] r_res_im;
    t_status                  r_res_st;
    logic signed [DATA_W-1:0] r_out_re;
    logic signed [DATA_W-1:0] r_out_im;
    logic [STAT_W-1:0]        r_out_st;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_re <= '0;
            r_res_im <= '0;
            r_res_st <= w_stat;
        end else if (i_cmd.cap_read) begin
            r_res_re <= w_rdata[WORD_W-1:DATA_W];
            r_res_im <= w_rdata[DATA_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_re <= r_res_re;
            r_out_im <= r_res_im;
            r_out_st <= r_res_st;
        end
    end

    assign o_status.kind = w_kind;
    assign o_status.last = r_last;
    assign o_read_real   = r_out_re;
    assign o_read_imag   = r_out_im;
    assign o_status_code = r_out_st;

endmodule

// ----- rtl/qsvg_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences one item at a time through the datapath and owns the handshakes.
module qsvg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_stall,
    input  qsvg_pkg::t_dp_status i_dp,
    output qsvg_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);

    import qsvg_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output valid: set on load, cleared once the result is transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_dp.kind)
                        K_READ:  n_state = S_RD;
                        K_SWAP:  n_state = S_X_RA;
                        K_HAD:   n_state = S_H_RA;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RD:   n_state = S_DONE;
            S_X_RA: n_state = S_X_RB;
            S_X_RB: n_state = S_X_WA;
            S_X_WA: n_state = S_X_WB;
            S_X_WB: n_state = i_dp.last ? S_DONE : S_X_RB;
            S_H_RA: n_state = S_H_RB;
            S_H_RB: n_state = S_H_CB;
            S_H_CB: n_state = S_H_MS;
            S_H_MS: n_state = S_H_WA;
            S_H_WA: n_state = S_H_WB;
            S_H_WB: n_state = i_dp.last ? S_DONE : S_H_RB;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_IDX;
        o_cmd.wr_sel = WR_INPUT;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = w_accept;
                o_cmd.wr_en  = w_accept && (i_dp.kind == K_WRITE);
            end
            S_RD: begin
                o_cmd.cap_read = 1'b1;
            end
            S_X_RA, S_H_RA: begin
                o_cmd.issue_a = 1'b1;
                o_cmd.rd_sel  = RD_A;
            end
            S_X_RB, S_H_RB: begin
                o_cmd.rd_sel = RD_B;
                o_cmd.cap_a  = 1'b1;
            end
            S_X_WA: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_A_RDATA;
            end
            S_X_WB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_B_RA;
                o_cmd.issue_a = !i_dp.last;
                o_cmd.rd_sel  = RD_A;
            end
            S_H_CB: begin
                o_cmd.cap_b = 1'b1;
            end
            S_H_MS: begin
                o_cmd.mul_en = 1'b1;
            end
            S_H_WA: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = WR_A_HAD;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_diff = 1'b1;
            end
            S_H_WB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_B_HAD;
                o_cmd.issue_a = !i_dp.last;
                o_cmd.rd_sel  = RD_A;
            end
            S_DONE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_cmd.accept = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/qubit_state_vector_gate_engine.sv -----
`timescale 1ns / 1ps
// Top level of the qubit state-vector gate engine: controller, datapath and checks.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_stall      opcode, qubits, index, write amplitude
//  result    out        o_out_valid / i_out_stall    read amplitude, status
//  config    in         i_cfg_we                     i_cfg_data (qubit count)
//
// One item at a time; n is the clamped qubit count, the walk covers 2^(n-1) pairs.
// X and CNOT read and write each pair in turn, paced by the registered read of the store;
// Hadamard adds the capture and multiply steps. Write and rejected or unknown items go
// straight to the final state; read first captures the addressed amplitude.
// Reset is synchronous; the store is not cleared. A stalled result sits in the output
// register while the next item runs; that item then waits in its final state until
// the output register is free.
module qubit_state_vector_gate_engine #(
    parameter int MAX_QUBITS = qsvg_pkg::MAX_QUBITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic        [qsvg_pkg::QCNT_W-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic        [qsvg_pkg::OPC_W-1:0]   i_opcode,
    input  logic        [qsvg_pkg::QUBIT_W-1:0] i_target_qubit,
    input  logic        [qsvg_pkg::QUBIT_W-1:0] i_control_qubit,
    input  logic        [qsvg_pkg::IDX_W-1:0]   i_amp_index,
    input  logic signed [qsvg_pkg::DATA_W-1:0]  i_write_real,
    input  logic signed [qsvg_pkg::DATA_W-1:0]  i_write_imag,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [qsvg_pkg::DATA_W-1:0]  o_read_real,
    output logic signed [qsvg_pkg::DATA_W-1:0]  o_read_imag,
    output logic        [qsvg_pkg::STAT_W-1:0]  o_status
);

    import qsvg_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_dp;

    qsvg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_dp        (w_dp),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    qsvg_datapath #(
        .MAX_QUBITS (MAX_QUBITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_target_qubit  (i_target_qubit),
        .i_control_qubit (i_control_qubit),
        .i_amp_index     (i_amp_index),
        .i_write_real    (i_write_real),
        .i_write_imag    (i_write_imag),
        .i_cmd           (w_cmd),
        .o_status        (w_dp),
        .o_read_real     (o_read_real),
        .o_read_imag     (o_read_imag),
        .o_status_code   (o_status)
    );

    // A transfer in always starts work that blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // A new result appears only at the end of an item's work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work in progress");

    // Status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_QUBIT || o_status == ST_INDEX))
        else $error("undefined status code");

    // Error results carry no amplitude
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_read_real == '0 && o_read_imag == '0))
        else $error("error result with nonzero amplitude");

endmodule
